// File: hw/rtl/sle_pkg.sv
`default_nettype none
package sle_pkg;

    localparam logic [1:0] CMD_FIND      = 2'd0;
    localparam logic [1:0] CMD_INSERT    = 2'd1;
    localparam logic [1:0] CMD_DELETE    = 2'd2;
    localparam logic [1:0] CMD_PARTITION = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_BADPOS   = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic load;
        logic put;
        logic scan_start;
        logic scatter_start;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       fail;
        logic       scan_done;
        logic       scatter;
    } dp_stat_t;

endpackage
`default_nettype wire

// File: hw/rtl/sequential_list_engine_core.sv
// Find, insert, delete and partition each walk the list RAM, one entry per cycle;
// partition walks it twice. A rejected insert or delete skips the walk.
// One request at a time; the next request is taken in the cycle done is high.
// done is a one-cycle strobe; the receiver cannot stall.
// Reset empties the list; entry storage is not cleared and needs no clearing pass.
`default_nettype none
module sequential_list_engine_core #(
    parameter int CAPACITY = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         command,
    input  wire logic signed [31:0] value,
    input  wire logic [4:0]         position,
    output logic                    done,
    output logic [1:0]              status,
    output logic [3:0]              found_index,
    output logic [4:0]              length
);
    import sle_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    sle_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .stat  (stat)
    );

    sle_datapath #(.CAPACITY(CAPACITY)) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .command     (command),
        .value       (value),
        .position    (position),
        .done        (done),
        .status      (status),
        .found_index (found_index),
        .length      (length)
    );

endmodule
`default_nettype wire

// File: hw/rtl/sle_ram.sv
`default_nettype none
module sle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// File: hw/rtl/sle_datapath.sv
`default_nettype none
module sle_datapath #(
    parameter int CAPACITY = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire sle_pkg::dp_cmd_t   cmd,
    output sle_pkg::dp_stat_t       stat,
    input  wire logic [1:0]         command,
    input  wire logic signed [31:0] value,
    input  wire logic [4:0]         position,
    output logic                    done,
    output logic [1:0]              status,
    output logic [3:0]              found_index,
    output logic [4:0]              length
);
    import sle_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int EW = (CW > 5) ? CW : 5;

    // control state
    logic [CW-1:0] count_reg;
    logic          bank_reg;
    logic          active_reg;
    logic [CW-1:0] rd_ptr_reg;
    logic          rv_reg;
    logic          scatter_reg;
    logic          found_reg;
    logic          done_reg;

    // payload
    logic [1:0]        op_reg;
    logic [1:0]        status_reg;
    logic signed [31:0] value_reg;
    logic [EW-1:0]     pos_reg;
    logic [CW-1:0]     ridx_reg;
    logic [CW-1:0]     found_idx_reg;
    logic signed [31:0] pivot_reg;
    logic [CW-1:0]     s_reg;
    logic [CW-1:0]     lo_reg;
    logic [CW-1:0]     hi_reg;
    logic [1:0]        status_o_reg;
    logic [3:0]        found_o_reg;
    logic [4:0]        length_o_reg;

    logic [1:0]    load_status;
    logic [EW-1:0] pos_in_ext;
    logic [EW-1:0] cnt_ext;
    logic [EW-1:0] ridx_ext;
    logic [EW-1:0] found_ext;
    logic [EW-1:0] len_ext;
    logic [CW-1:0] count_after;
    logic [CW-1:0] ridx_inc;
    logic [CW-1:0] ridx_dec;
    logic          fail;
    logic          issue;
    logic          smaller;
    logic          match;
    logic [31:0]   rdata;
    logic [31:0]   rd0;
    logic [31:0]   rd1;
    logic          we;
    logic [AW-1:0] waddr;
    logic [31:0]   wdata;

    assign pos_in_ext = EW'(position);
    assign cnt_ext    = EW'(count_reg);
    assign ridx_ext   = EW'(ridx_reg);
    assign found_ext  = EW'(found_idx_reg);
    assign ridx_inc   = ridx_reg + 1'b1;
    assign ridx_dec   = ridx_reg - 1'b1;
    assign fail       = (status_reg != ST_OK);
    assign issue      = active_reg && (rd_ptr_reg < count_reg);
    assign rdata      = bank_reg ? rd1 : rd0;
    assign smaller    = ($signed(rdata) < pivot_reg);
    assign match      = (rdata == value_reg);

    always_comb
    begin
        load_status = ST_OK;
        case (command)
            CMD_INSERT:
            begin
                if (count_reg == CW'(CAPACITY))
                begin
                    load_status = ST_FULL;
                end
                else if (pos_in_ext > cnt_ext)
                begin
                    load_status = ST_BADPOS;
                end
            end
            CMD_DELETE:
            begin
                if (pos_in_ext >= cnt_ext)
                begin
                    load_status = ST_BADPOS;
                end
            end
            default:
            begin
                load_status = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        count_after = count_reg;
        if (!fail && op_reg == CMD_INSERT)
        begin
            count_after = count_reg + 1'b1;
        end
        else if (!fail && op_reg == CMD_DELETE)
        begin
            count_after = count_reg - 1'b1;
        end
    end

    assign len_ext = EW'(count_after);

    // write side of the shadow bank
    always_comb
    begin
        we    = 1'b0;
        waddr = ridx_reg[AW-1:0];
        wdata = rdata;
        if (cmd.put)
        begin
            we    = 1'b1;
            waddr = pos_reg[AW-1:0];
            wdata = value_reg;
        end
        else if (rv_reg)
        begin
            case (op_reg)
                CMD_INSERT:
                begin
                    we    = 1'b1;
                    waddr = (ridx_ext < pos_reg) ? ridx_reg[AW-1:0] : ridx_inc[AW-1:0];
                end
                CMD_DELETE:
                begin
                    we    = (ridx_ext != pos_reg);
                    waddr = (ridx_ext < pos_reg) ? ridx_reg[AW-1:0] : ridx_dec[AW-1:0];
                end
                CMD_PARTITION:
                begin
                    we = scatter_reg;
                    if (ridx_reg == '0)
                    begin
                        waddr = s_reg[AW-1:0];
                    end
                    else if (smaller)
                    begin
                        waddr = lo_reg[AW-1:0];
                    end
                    else
                    begin
                        waddr = hi_reg[AW-1:0];
                    end
                end
                default:
                begin
                    we = 1'b0;
                end
            endcase
        end
    end

    sle_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_bank0 (
        .clk   (clk),
        .we    (we & bank_reg),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (rd_ptr_reg[AW-1:0]),
        .rdata (rd0)
    );

    sle_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_bank1 (
        .clk   (clk),
        .we    (we & ~bank_reg),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (rd_ptr_reg[AW-1:0]),
        .rdata (rd1)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            bank_reg    <= 1'b0;
            active_reg  <= 1'b0;
            rd_ptr_reg  <= '0;
            rv_reg      <= 1'b0;
            scatter_reg <= 1'b0;
            found_reg   <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.scan_start || cmd.scatter_start)
            begin
                active_reg <= 1'b1;
                rd_ptr_reg <= '0;
            end
            else if (active_reg)
            begin
                if (issue)
                begin
                    rd_ptr_reg <= rd_ptr_reg + 1'b1;
                end
                else
                begin
                    active_reg <= 1'b0;
                end
            end
            rv_reg <= issue;

            if (cmd.load)
            begin
                scatter_reg <= 1'b0;
                found_reg   <= 1'b0;
            end
            else
            begin
                if (cmd.scatter_start)
                begin
                    scatter_reg <= 1'b1;
                end
                if (rv_reg && op_reg == CMD_FIND && match)
                begin
                    found_reg <= 1'b1;
                end
            end

            done_reg <= cmd.finish;
            if (cmd.finish && !fail)
            begin
                count_reg <= count_after;
                if (op_reg != CMD_FIND)
                begin
                    bank_reg <= ~bank_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ridx_reg <= rd_ptr_reg;
        if (cmd.load)
        begin
            op_reg        <= command;
            value_reg     <= value;
            pos_reg       <= pos_in_ext;
            status_reg    <= load_status;
            s_reg         <= '0;
            found_idx_reg <= '0;
        end
        if (cmd.scatter_start)
        begin
            lo_reg <= s_reg - 1'b1;
            hi_reg <= s_reg + 1'b1;
        end
        if (rv_reg)
        begin
            if (op_reg == CMD_FIND && !found_reg && match)
            begin
                found_idx_reg <= ridx_reg;
            end
            if (op_reg == CMD_PARTITION && !scatter_reg)
            begin
                if (ridx_reg == '0)
                begin
                    pivot_reg <= $signed(rdata);
                end
                else if (smaller)
                begin
                    s_reg <= s_reg + 1'b1;
                end
            end
            if (op_reg == CMD_PARTITION && scatter_reg && ridx_reg != '0)
            begin
                if (smaller)
                begin
                    lo_reg <= lo_reg - 1'b1;
                end
                else
                begin
                    hi_reg <= hi_reg + 1'b1;
                end
            end
        end
        if (cmd.finish)
        begin
            length_o_reg <= len_ext[4:0];
            if (op_reg == CMD_FIND)
            begin
                status_o_reg <= found_reg ? ST_OK : ST_NOTFOUND;
                found_o_reg  <= found_reg ? found_ext[3:0] : 4'd0;
            end
            else
            begin
                status_o_reg <= status_reg;
                found_o_reg  <= 4'd0;
            end
        end
    end

    assign stat.op        = op_reg;
    assign stat.fail      = fail;
    assign stat.scan_done = !active_reg && !rv_reg;
    assign stat.scatter   = scatter_reg;

    assign done        = done_reg;
    assign status      = status_o_reg;
    assign found_index = found_o_reg;
    assign length      = length_o_reg;

endmodule
`default_nettype wire

// File: hw/rtl/sle_ctrl.sv
`default_nettype none
module sle_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    output sle_pkg::dp_cmd_t      cmd,
    input  wire sle_pkg::dp_stat_t stat
);
    import sle_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_PUT    = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.fail)
                begin
                    state_next = S_FINISH;
                end
                else if (stat.op == CMD_INSERT)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_PUT:
            begin
                cmd.put        = 1'b1;
                cmd.scan_start = 1'b1;
                state_next     = S_SCAN;
            end
            S_SCAN:
            begin
                if (stat.scan_done)
                begin
                    if (stat.op == CMD_PARTITION && !stat.scatter)
                    begin
                        cmd.scatter_start = 1'b1;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule
`default_nettype wire

// File: verif/sequential_list_engine_core_tb.sv
`default_nettype none
module sequential_list_engine_core_tb;
    import sle_pkg::*;

    localparam int CAPACITY     = 16;
    localparam int RANDOM_ITEMS = 550;
    localparam int QUIET_TAIL   = 100;
    localparam int WATCHDOG     = 2000;

    typedef struct packed {
        logic [1:0] st;
        logic [3:0] idx;
        logic [4:0] len;
    } result_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] val;
        logic [4:0]  pos;
        logic [4:0]  rep;
        logic        typed;
        result_t     want;
    } step_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         command;
    logic signed [31:0] value;
    logic [4:0]         position;
    logic               done;
    logic [1:0]         status;
    logic [3:0]         found_index;
    logic [4:0]         length;

    logic signed [31:0] shadow_list [CAPACITY];
    int                 shadow_len;
    result_t            pending_results [$];

    logic               cur_typed;
    result_t            cur_want;
    int                 accepted_count;
    int                 results_seen;
    int                 errors;
    int                 quiet_cycles;
    int                 status_seen [4];
    step_t              dir_steps [0:19];

    sequential_list_engine_core #(
        .CAPACITY(CAPACITY)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .command(command),
        .value(value),
        .position(position),
        .done(done),
        .status(status),
        .found_index(found_index),
        .length(length)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic result_t list_apply(logic [1:0] cmd, logic signed [31:0] val,
                                           logic [4:0] pos);
        result_t            r;
        int                 i;
        int                 j;
        logic signed [31:0] pivot;
        logic signed [31:0] y;
        r.st  = ST_OK;
        r.idx = 4'd0;
        case (cmd)
            CMD_FIND:
            begin
                i = 0;
                while (i < shadow_len && shadow_list[i] != val)
                    i++;
                if (i >= shadow_len)
                    r.st = ST_NOTFOUND;
                else
                    r.idx = i[3:0];
            end
            CMD_INSERT:
            begin
                if (shadow_len >= CAPACITY)
                    r.st = ST_FULL;
                else if (pos > shadow_len)
                    r.st = ST_BADPOS;
                else
                begin
                    for (i = shadow_len; i > pos; i--)
                        shadow_list[i] = shadow_list[i-1];
                    shadow_list[pos] = val;
                    shadow_len++;
                end
            end
            CMD_DELETE:
            begin
                if (pos >= shadow_len)
                    r.st = ST_BADPOS;
                else
                begin
                    for (i = pos + 1; i < shadow_len; i++)
                        shadow_list[i-1] = shadow_list[i];
                    shadow_len--;
                end
            end
            default:
            begin
                if (shadow_len > 0)
                begin
                    pivot = shadow_list[0];
                    for (i = 1; i < shadow_len; i++)
                    begin
                        if (shadow_list[i] < pivot)
                        begin
                            y = shadow_list[i];
                            for (j = i; j > 0; j--)
                                shadow_list[j] = shadow_list[j-1];
                            shadow_list[0] = y;
                        end
                    end
                end
            end
        endcase
        r.len = shadow_len[4:0];
        return r;
    endfunction

    function automatic step_t mk(logic [1:0] c, logic [31:0] v, logic [4:0] p, logic [4:0] n,
                                 logic t, logic [1:0] s, logic [3:0] i, logic [4:0] l);
        step_t row;
        row.cmd      = c;
        row.val      = v;
        row.pos      = p;
        row.rep      = n;
        row.typed    = t;
        row.want.st  = s;
        row.want.idx = i;
        row.want.len = l;
        return row;
    endfunction

    function automatic logic [31:0] rand_value();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            return 32'($urandom_range(0, 20)) - 32'd10;
        if (pick == 4)
        begin
            case ($urandom_range(0, 3))
                0: return 32'h8000_0000;
                1: return 32'h7fff_ffff;
                2: return 32'h0000_0000;
                default: return 32'hffff_ffff;
            endcase
        end
        return $urandom;
    endfunction

    // returns at the falling edge after acceptance, start still high
    task automatic send_request(logic [1:0] c, logic [31:0] v, logic [4:0] p,
                                logic t, result_t w);
        int seen;
        seen      = accepted_count;
        start     = 1'b1;
        command   = c;
        value     = v;
        position  = p;
        cur_typed = t;
        cur_want  = w;
        while (accepted_count == seen)
            @(negedge clk);
    endtask

    task automatic maybe_pause(bit allow);
        if (allow && $urandom_range(0, 3) == 0)
        begin
            start = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
    endtask

    always @(posedge clk)
    begin : monitor
        result_t want;
        bit      progress;
        if (rst_n)
        begin
            progress = 1'b0;
            if (done === 1'b1)
            begin
                progress = 1'b1;
                results_seen++;
                if (pending_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result status %0d index %0d length %0d",
                             $time, status, found_index, length);
                end
                else
                begin
                    want = pending_results.pop_front();
                    status_seen[want.st]++;
                    if (status !== want.st)
                    begin
                        errors++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.st, status);
                    end
                    if (found_index !== want.idx)
                    begin
                        errors++;
                        $display("%0t: found_index expected %0d actual %0d",
                                 $time, want.idx, found_index);
                    end
                    if (length !== want.len)
                    begin
                        errors++;
                        $display("%0t: length expected %0d actual %0d",
                                 $time, want.len, length);
                    end
                end
            end
            if (start === 1'b1 && busy === 1'b0)
            begin
                progress = 1'b1;
                want = list_apply(command, value, position);
                pending_results.push_back(cur_typed ? cur_want : want);
                accepted_count++;
            end
            if (progress)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG)
            begin
                $display("%0t: watchdog expired, %0d results outstanding",
                         $time, pending_results.size());
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        step_t      row;
        logic [1:0] c;
        logic [31:0] v;
        logic [4:0] p;
        int         w;
        int         k;
        int         n;
        int         directed;
        bit         grow;
        bit         idle_on;

        rst_n          = 1'b0;
        start          = 1'b0;
        command        = CMD_FIND;
        value          = '0;
        position       = '0;
        cur_typed      = 1'b0;
        cur_want       = '0;
        shadow_len     = 0;
        accepted_count = 0;
        results_seen   = 0;
        errors         = 0;
        quiet_cycles   = 0;
        for (k = 0; k < 4; k++)
            status_seen[k] = 0;
        for (k = 0; k < CAPACITY; k++)
            shadow_list[k] = '0;

        dir_steps[0]  = mk(CMD_FIND,      32'h0000_0000, 5'd0,  5'd1,  1, ST_NOTFOUND, 0, 0);
        dir_steps[1]  = mk(CMD_DELETE,    32'hffff_ffff, 5'd0,  5'd1,  1, ST_BADPOS,   0, 0);
        dir_steps[2]  = mk(CMD_PARTITION, 32'h8000_0000, 5'd31, 5'd1,  1, ST_OK,       0, 0);
        dir_steps[3]  = mk(CMD_INSERT,    32'h0000_0000, 5'd31, 5'd1,  1, ST_BADPOS,   0, 0);
        dir_steps[4]  = mk(CMD_INSERT,    32'h7fff_ffff, 5'd0,  5'd1,  1, ST_OK,       0, 1);
        dir_steps[5]  = mk(CMD_INSERT,    32'h8000_0000, 5'd1,  5'd1,  1, ST_OK,       0, 2);
        dir_steps[6]  = mk(CMD_INSERT,    32'hffff_ffff, 5'd1,  5'd1,  0, ST_OK,       0, 0);
        dir_steps[7]  = mk(CMD_INSERT,    32'h0000_0000, 5'd0,  5'd1,  0, ST_OK,       0, 0);
        dir_steps[8]  = mk(CMD_PARTITION, 32'h1234_5678, 5'd9,  5'd1,  0, ST_OK,       0, 0);
        dir_steps[9]  = mk(CMD_FIND,      32'h8000_0000, 5'd31, 5'd1,  0, ST_OK,       0, 0);
        dir_steps[10] = mk(CMD_FIND,      32'h1234_5678, 5'd0,  5'd1,  1, ST_NOTFOUND, 0, 4);
        dir_steps[11] = mk(CMD_INSERT,    32'h5a5a_5a5a, 5'd4,  5'd12, 0, ST_OK,       0, 0);
        dir_steps[12] = mk(CMD_INSERT,    32'h0000_0001, 5'd0,  5'd1,  1, ST_FULL,     0, 16);
        dir_steps[13] = mk(CMD_INSERT,    32'h0000_0001, 5'd31, 5'd1,  1, ST_FULL,     0, 16);
        dir_steps[14] = mk(CMD_FIND,      32'h7fff_ffff, 5'd16, 5'd1,  0, ST_OK,       0, 0);
        dir_steps[15] = mk(CMD_DELETE,    32'h0000_0000, 5'd16, 5'd1,  1, ST_BADPOS,   0, 16);
        dir_steps[16] = mk(CMD_DELETE,    32'h0000_0000, 5'd31, 5'd1,  1, ST_BADPOS,   0, 16);
        dir_steps[17] = mk(CMD_DELETE,    32'h0000_0000, 5'd15, 5'd1,  1, ST_OK,       0, 15);
        dir_steps[18] = mk(CMD_DELETE,    32'hffff_ffff, 5'd0,  5'd1,  1, ST_OK,       0, 14);
        dir_steps[19] = mk(CMD_PARTITION, 32'h0000_0000, 5'd0,  5'd1,  0, ST_OK,       0, 0);

        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (k = 0; k < 20; k++)
        begin
            row = dir_steps[k];
            for (n = 0; n < row.rep; n++)
            begin
                maybe_pause(1'b1);
                send_request(row.cmd, row.val + 32'(n), row.pos, row.typed, row.want);
            end
        end
        directed = accepted_count;

        grow    = 1'b0;
        idle_on = 1'b1;
        for (k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k % 40 == 0)
                idle_on = ($urandom_range(0, 2) != 0);
            if (k >= RANDOM_ITEMS - QUIET_TAIL)
                idle_on = 1'b0;
            if (shadow_len == CAPACITY)
                grow = 1'b0;
            if (shadow_len == 0)
                grow = 1'b1;
            w = $urandom_range(0, 99);
            if (grow)
                c = (w < 55) ? CMD_INSERT : (w < 70) ? CMD_DELETE :
                    (w < 90) ? CMD_FIND : CMD_PARTITION;
            else
                c = (w < 15) ? CMD_INSERT : (w < 70) ? CMD_DELETE :
                    (w < 90) ? CMD_FIND : CMD_PARTITION;
            p = 5'($urandom_range(0, 31));
            v = rand_value();
            case (c)
                CMD_INSERT:
                    if ($urandom_range(0, 6) != 0)
                        p = 5'($urandom_range(0, shadow_len));
                CMD_DELETE:
                    if (shadow_len > 0 && $urandom_range(0, 6) != 0)
                        p = 5'($urandom_range(0, shadow_len - 1));
                CMD_FIND:
                    if (shadow_len > 0 && $urandom_range(0, 4) < 3)
                        v = shadow_list[$urandom_range(0, shadow_len - 1)];
                default:
                    ;
            endcase
            maybe_pause(idle_on);
            send_request(c, v, p, 1'b0, '0);
        end

        start = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);

        $display("%0d requests (%0d directed), %0d results checked", accepted_count,
                 directed, results_seen);
        $display("status mix: ok %0d, full %0d, bad position %0d, not found %0d",
                 status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_BADPOS],
                 status_seen[ST_NOTFOUND]);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
`default_nettype wire
